// ===== sv/dre_pkg.sv =====
// ----------------------------------------------------------------------------
// dre_pkg
// Shared types, constants and helper functions of the reachability engine.
// ----------------------------------------------------------------------------
package dre_pkg;

  localparam int MAX_NODES   = 32;
  localparam int ROW_W       = 32;
  localparam int ROWS        = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int CFG_W       = 6;
  localparam int ACT_LIMIT   = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int RESET_COUNT = 32;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } dre_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } dre_state_t;

  typedef struct packed {
    dre_cmd_t             cmd;
    logic [IDX_W-1:0]     node;
    logic [ROW_W-1:0]     row_bits;
    logic [IDX_W-1:0]     target;
  } in_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]     direct_successors;
    logic [ROW_W-1:0]     all_successors;
    logic [ROW_W-1:0]     predecessors;
    logic                 is_init;
    logic                 is_last;
    logic                 target_reachable;
    logic                 bad_index;
  } out_rsp_t;

  // Mask of the rows in use: one low bit for each active node.
  function automatic logic [ROW_W-1:0] count_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    if (n >= CNT_W'(ROW_W)) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << n) - ROW_W'(1);
    end
    return m;
  endfunction

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [IDX_W-1:0] lowest_index(input logic [ROW_W-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/dre_ram.sv =====
// ----------------------------------------------------------------------------
// dre_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dag_reachability_engine_top.sv =====
// ----------------------------------------------------------------------------
// dag_reachability_engine_top
// Adjacency matrix store with transitive closure and column queries.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on in_data and are taken at a rising edge with start high
//   and busy low. A load request (cmd load) writes one successor row, masked
//   to the active node count, and returns nothing; busy
//   stays low, so loads may follow each other in every cycle.
//   A query request returns one result on out_data, marked by a one-cycle
//   out_valid strobe. The receiver cannot stall: the result is taken in the
//   cycle it is shown, and the output register lets the next request enter
//   while it is on display.
//   Query timing: a bad node or target index gives its result in the cycle
//   after acceptance. A valid query's result follows the column sweep, which
//   reads every active row; the closure walk, which expands at most n nodes,
//   n the active node count, never outlasts it. Two copies of the row memory
//   let both run together: one feeds the closure worklist a row per cycle,
//   the other sweeps every row to gather the predecessor column at the same
//   time. node_count is written through cfg_we / cfg_wdata by the user, only
//   while idle; the block does not enforce this. Reset (rst_n low, synchronous)
//   clears every row to no edges by valid bits, sets node_count to 32 and
//   drops any query in flight.
// ----------------------------------------------------------------------------
module dag_reachability_engine_top import dre_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_req_t          in_data,
  output logic             busy,
  output logic             out_valid,
  output out_rsp_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(ACT_LIMIT);

  dre_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] node_count_r;
  logic [ROWS-1:0]  valid_r;

  logic [IDX_W-1:0] node_r, node_nxt;
  logic [IDX_W-1:0] target_r, target_nxt;
  logic [ROW_W-1:0] reach_r, reach_nxt;
  logic [ROW_W-1:0] visited_r, visited_nxt;
  logic [ROW_W-1:0] direct_r, direct_nxt;
  logic [ROW_W-1:0] pred_r, pred_nxt;
  logic             a_pend_r, a_pend_nxt;
  logic             first_r, first_nxt;
  logic             s_pend_r, s_pend_nxt;
  logic [IDX_W-1:0] a_idx_r;
  logic [IDX_W-1:0] s_idx_r;
  logic [CNT_W-1:0] scnt_r, scnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_data_r, out_data_nxt;

  logic [CNT_W-1:0] n_act;
  logic [ROW_W-1:0] cmask;
  logic             accept;
  logic             load_ok;
  logic             query_bad;
  logic             ram_we;
  logic [IDX_W-1:0] a_raddr, b_raddr;
  logic [ROW_W-1:0] a_rdata, b_rdata;
  logic [ROW_W-1:0] row_a;
  logic             col_hit;
  logic [ROW_W-1:0] reach_cur;
  logic [ROW_W-1:0] pending;

  // Active count: node_count limited to what the matrix holds.
  assign n_act     = (node_count_r > LIMIT) ? LIMIT : node_count_r;
  assign cmask     = count_mask(n_act);
  assign accept    = start & ~busy;
  assign query_bad = ({1'b0, in_data.node} >= n_act) || ({1'b0, in_data.target} >= n_act);
  assign load_ok   = accept && (in_data.cmd == CMD_LOAD) && ({1'b0, in_data.node} < n_act);
  assign ram_we    = load_ok;

  // A row never written reads as no edges; stale high bits are masked.
  assign row_a   = valid_r[a_idx_r] ? (a_rdata & cmask) : '0;
  assign col_hit = s_pend_r & valid_r[s_idx_r] & b_rdata[node_r];

  // Merge the row returned for the last expanded node before choosing the next.
  assign reach_cur = a_pend_r ? (reach_r | row_a) : reach_r;
  assign pending   = reach_cur & ~visited_r;

  // Closure copy of the matrix.
  dre_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram_walk (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.node),
    .wdata (in_data.row_bits & cmask),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Column sweep copy of the matrix, written in step with the first.
  dre_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram_sweep (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.node),
    .wdata (in_data.row_bits & cmask),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    target_nxt    = target_r;
    reach_nxt     = reach_r;
    visited_nxt   = visited_r;
    direct_nxt    = direct_r;
    pred_nxt      = pred_r;
    a_pend_nxt    = 1'b0;
    first_nxt     = 1'b0;
    s_pend_nxt    = 1'b0;
    scnt_nxt      = scnt_r;
    a_raddr       = in_data.node;
    b_raddr       = scnt_r[IDX_W-1:0];
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.cmd == CMD_QUERY)) begin
          reach_nxt   = '0;
          visited_nxt = '0;
          if (query_bad) begin
            // Report the bad index at once with every other field clear.
            out_valid_nxt          = 1'b1;
            out_data_nxt           = '0;
            out_data_nxt.bad_index = 1'b1;
          end else begin
            // Fetch the queried row; it seeds the worklist.
            a_raddr    = in_data.node;
            a_pend_nxt = 1'b1;
            first_nxt  = 1'b1;
            pred_nxt   = '0;
            scnt_nxt   = '0;
            node_nxt   = in_data.node;
            target_nxt = in_data.target;
            state_nxt  = S_WALK;
          end
        end
      end

      S_WALK: begin
        reach_nxt = reach_cur;
        if (first_r) begin
          direct_nxt = row_a;
        end
        // Expand the lowest reached node not yet visited.
        if (pending != '0) begin
          a_raddr     = lowest_index(pending);
          a_pend_nxt  = 1'b1;
          visited_nxt = visited_r | (pending & (~pending + ROW_W'(1)));
        end
        // Advance the column sweep over the active rows.
        if (scnt_r < n_act) begin
          b_raddr    = scnt_r[IDX_W-1:0];
          s_pend_nxt = 1'b1;
          scnt_nxt   = scnt_r + CNT_W'(1);
        end
        if (col_hit) begin
          pred_nxt = pred_r | (ROW_W'(1) << s_idx_r);
        end
        // Both walks drained: hand over the result.
        if (!a_pend_r && (pending == '0) && (scnt_r >= n_act) && !s_pend_r) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.direct_successors = direct_r;
          out_data_nxt.all_successors    = reach_r;
          out_data_nxt.predecessors      = pred_r;
          out_data_nxt.is_init           = (pred_r == '0);
          out_data_nxt.is_last           = (direct_r == '0);
          out_data_nxt.target_reachable  = reach_r[target_r];
          out_data_nxt.bad_index         = 1'b0;
          state_nxt                      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= CNT_W'(RESET_COUNT);
      valid_r      <= '0;
      a_pend_r     <= 1'b0;
      first_r      <= 1'b0;
      s_pend_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_pend_r    <= a_pend_nxt;
      first_r     <= first_nxt;
      s_pend_r    <= s_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (ram_we) begin
        valid_r[in_data.node] <= 1'b1;
      end
    end
  end

  // Datapath registers; the index registers track the RAM read addresses.
  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    target_r   <= target_nxt;
    reach_r    <= reach_nxt;
    visited_r  <= visited_nxt;
    direct_r   <= direct_nxt;
    pred_r     <= pred_nxt;
    scnt_r     <= scnt_nxt;
    a_idx_r    <= a_raddr;
    s_idx_r    <= b_raddr;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/dre_checker.sv =====
// ----------------------------------------------------------------------------
// dre_checker
// Port-level checks of the reachability engine, bound to the top level.
// ----------------------------------------------------------------------------
module dre_checker import dre_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_valid,
  input out_rsp_t out_data
);

  // Reset leaves no strobe and no request in flight.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> (!out_valid && !busy))
    else $error("strobe or busy after reset");

  // A bad index result carries nothing else.
  a_bad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_index) |->
      (out_data.direct_successors == '0 && out_data.all_successors == '0 &&
       out_data.predecessors == '0 && !out_data.is_init && !out_data.is_last &&
       !out_data.target_reachable))
    else $error("bad index result with fields set");

  // Direct successors are always part of the closure.
  a_direct_in_closure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.direct_successors & ~out_data.all_successors) == '0))
    else $error("direct successor missing from closure");

  // Flags agree with the masks they summarise.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.bad_index) |->
      ((out_data.is_last == (out_data.direct_successors == '0)) &&
       (out_data.is_init == (out_data.predecessors == '0))))
    else $error("is_init or is_last inconsistent");

endmodule

bind dag_reachability_engine_top dre_checker u_dre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
